[src/wte_pkg.sv]
package wte_pkg;

	// Scanner modes; encodings 6 and 7 are never produced.
	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_ESCAPE     = 3'd1,
		MODE_DOT        = 3'd2,
		MODE_COUNT_LOW  = 3'd3,
		MODE_COUNT_HIGH = 3'd4,
		MODE_DROP       = 3'd5
	} mode_t;

	// One result item.
	typedef struct packed {
		logic [7:0] regex_byte;
		logic       regex_end;
		logic       syntax_error;
	} item_t;

	// Decode of one pattern byte: up to two result items and the next mode.
	typedef struct packed {
		logic [1:0] count;
		item_t      item0;
		item_t      item1;
		mode_t      next_mode;
	} decode_t;

	localparam int unsigned QUEUE_DEPTH = 4;

endpackage

[src/wte_decode.sv]
module wte_decode import wte_pkg::*; (
	input  mode_t      mode,
	input  logic [7:0] pattern_byte,
	input  logic       pattern_end,
	output decode_t    result
);

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	function automatic item_t mk_item(input logic [7:0] b, input logic last);
		item_t it;
		it.regex_byte   = b;
		it.regex_end    = last;
		it.syntax_error = 1'b0;
		return it;
	endfunction

	logic is_meta;
	logic is_digit;
	logic [7:0] sep;
	logic is_low;
	item_t err_item;

	always_comb begin
		is_meta = pattern_byte inside {8'h24, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h3F,
			8'h5B, 8'h5D, 8'h5E, 8'h7B, 8'h7C, 8'h7D};
		is_digit = (pattern_byte >= CH_ZERO) && (pattern_byte <= CH_NINE);
		is_low   = (mode == MODE_COUNT_LOW);
		sep      = is_low ? CH_COMMA : CH_RBRACE;
		err_item.regex_byte   = 8'h00;
		err_item.regex_end    = 1'b1;
		err_item.syntax_error = 1'b1;
	end

	always_comb begin
		result.count     = 2'd0;
		result.item0     = mk_item(pattern_byte, pattern_end);
		result.item1     = mk_item(pattern_byte, pattern_end);
		result.next_mode = MODE_NORMAL;
		case (mode)
			MODE_DROP: begin
				result.next_mode = pattern_end ? MODE_NORMAL : MODE_DROP;
			end
			MODE_ESCAPE: begin
				result.count = 2'd2;
				result.item0 = mk_item(CH_BSLASH, 1'b0);
			end
			MODE_DOT: begin
				if (pattern_byte == CH_DOT) begin
					result.item0 = mk_item(CH_DOT, 1'b0);
					result.item1 = mk_item(CH_DOT, 1'b1);
					result.count = pattern_end ? 2'd2 : 2'd1;
					result.next_mode = pattern_end ? MODE_NORMAL : MODE_DOT;
				end else if (pattern_byte == CH_LBRACE) begin
					if (pattern_end) begin
						result.count = 2'd1;
						result.item0 = err_item;
					end else begin
						result.count = 2'd2;
						result.item0 = mk_item(CH_DOT, 1'b0);
						result.item1 = mk_item(CH_LBRACE, 1'b0);
						result.next_mode = MODE_COUNT_LOW;
					end
				end else begin
					result.count = 2'd2;
					result.item0 = mk_item(CH_DOT, 1'b0);
				end
			end
			MODE_COUNT_LOW, MODE_COUNT_HIGH: begin
				result.count = 2'd1;
				if ((pattern_byte != sep) && !is_digit) begin
					result.item0 = err_item;
					result.next_mode = pattern_end ? MODE_NORMAL : MODE_DROP;
				end else if (pattern_end && !((pattern_byte == sep) && !is_low)) begin
					// end inside braces
					result.item0 = err_item;
				end else if (pattern_byte == sep) begin
					result.next_mode = is_low ? MODE_COUNT_HIGH : MODE_NORMAL;
				end else begin
					result.next_mode = mode;
				end
			end
			default: begin
				if (pattern_byte == CH_DOT) begin
					if (pattern_end) begin
						result.count = 2'd1;
					end else begin
						result.next_mode = MODE_DOT;
					end
				end else if (pattern_byte == CH_BSLASH) begin
					if (pattern_end) begin
						result.count = 2'd1;
						result.item0 = err_item;
					end else begin
						result.next_mode = MODE_ESCAPE;
					end
				end else if (is_meta) begin
					result.count = 2'd2;
					result.item0 = mk_item(CH_BSLASH, 1'b0);
				end else begin
					result.count = 2'd1;
				end
			end
		endcase
	end

endmodule

[src/wte_outq.sv]
module wte_outq import wte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_count,
	input  item_t      push_item0,
	input  item_t      push_item1,
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output item_t      out_item
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;
	logic [PTR_W-1:0]  wr_ptr_nx;

	assign out_valid = (count_q != '0);
	assign out_item  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	// two free entries needed for a worst-case push
	assign room      = (count_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign wr_ptr_nx = PTR_W'(wr_ptr_q + 1'b1);

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[wr_ptr_q] <= push_item0;
		end
		if (push_count == 2'd2) begin
			entry_q[wr_ptr_nx] <= push_item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + push_count);
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= CNT_W'(count_q + CNT_W'(push_count) - CNT_W'(pop));
		end
	end

endmodule

[src/wildcard_to_regex_escaper.sv]
// Wildcard-to-regex escaper. Pattern bytes enter on the s_axis side, one item
// per byte, with tlast on the final byte of a pattern; regex bytes leave on the
// m_axis side, tlast on the final result of the pattern. Metacharacters
// $ ( ) * + ? [ ] ^ { | } get a backslash; a backslash escapes the next byte;
// a dot is held until the next byte decides it (".{" opens a digits,digits}
// repeat count). A malformed pattern gives a single item with tuser set,
// tdata zero and tlast set; the consumer drops the bytes it already took for
// that pattern, and the rest of the pattern is swallowed without output.
// Rate: bytes that give zero or one result stream at one per clock while
// m_axis_tready stays high; a byte that gives two results (escapes, a dot
// followed by a byte other than a dot) is bounded by the one-byte output port.
// An accepted byte passes one input register, then is decoded into a
// four-entry output queue that offers the results. s_axis_tready drops
// only when the queue lacks room for two results.
module wildcard_to_regex_escaper import wte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] pattern_byte
	input  logic       s_axis_tlast,   // pattern_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] regex_byte
	output logic       m_axis_tlast,   // regex_end
	output logic [0:0] m_axis_tuser    // [0] syntax_error
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	mode_t      mode_q;
	decode_t    dec;
	logic       room;
	logic       advance;
	logic       in_accept;
	item_t      head;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_NORMAL;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				mode_q <= dec.next_mode;
			end
		end
	end

	// scanner: byte + mode -> up to two results
	wte_decode u_decode (
		.mode         (mode_q),
		.pattern_byte (byte_s1),
		.pattern_end  (end_s1),
		.result       (dec)
	);

	// result queue decouples the two-results case from the output handshake
	wte_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (advance ? dec.count : 2'd0),
		.push_item0 (dec.item0),
		.push_item1 (dec.item1),
		.room       (room),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_item   (head)
	);

	assign m_axis_tdata = head.regex_byte;
	assign m_axis_tlast = head.regex_end;
	assign m_axis_tuser = head.syntax_error;

endmodule

[src/wte_checker.sv]
module wte_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,
	input  logic       m_axis_tlast,
	input  logic [0:0] m_axis_tuser
);

	// a stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result valid dropped while stalled");

	// a stalled result keeps its payload
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// an error item closes the pattern and carries no byte
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'h00))
		else $error("malformed error item");

	// input side never stalls while output side is idle and empty
	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && $past(!m_axis_tvalid) && $past(!s_axis_tvalid)
			|-> s_axis_tready)
		else $error("input stalled with nothing pending");

endmodule

bind wildcard_to_regex_escaper wte_checker u_wte_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

[tb/wildcard_to_regex_escaper_test.sv]
module wildcard_to_regex_escaper_test;
	timeunit 1ns;
	timeprecision 1ps;
	import wte_pkg::*;

	// Pattern characters the scanner treats specially.
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	// The twelve regex metacharacters, one per byte lane.
	localparam logic [12*8-1:0] META_SET = "$()*+?[]^{|}";

	localparam item_t SYNTAX_ERR = {8'h00, 1'b1, 1'b1};
	localparam item_t NO_ITEM    = '0;

	localparam int RANDOM_ITEMS = 1900;
	localparam int DIR_ROWS     = 31;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [0:0] m_axis_tuser;

	// Receiver long hold-off, raised by the pressure process.
	logic hold_off = 1'b0;

	mode_t      pred_mode = MODE_NORMAL;   // predictor copy of the scanner mode
	item_t      regex_due[$];              // regex items still to arrive, oldest first
	logic [7:0] pattern_q[$];              // pattern being built for the random part
	int         items_fed = 0;             // accepted bytes not swallowed after an error
	int         mismatches = 0;

	// One directed item: the byte, its end flag, and optionally the typed-in
	// expectation (typed = 1) that replaces the predictor's output.
	typedef struct packed {
		logic [7:0] pat;
		logic       fin;
		logic       typed;
		logic [1:0] n;
		item_t      r0;
		item_t      r1;
	} row_t;

	row_t dir_rows [0:DIR_ROWS-1] = '{
		// extreme bytes straight after reset pass unchanged
		{8'h00, 1'b0, 1'b1, 2'd1, {8'h00, 1'b0, 1'b0}, NO_ITEM},
		{8'hFF, 1'b0, 1'b1, 2'd1, {8'hFF, 1'b0, 1'b0}, NO_ITEM},
		// every metacharacter picks up a backslash
		{"$", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"(", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{")", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"*", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"+", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"?", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"[", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"]", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"^", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"{", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"|", 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"}", 1'b1, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		// trailing backslash
		{CH_BSL, 1'b1, 1'b1, 2'd1, SYNTAX_ERR, NO_ITEM},
		// dot still pending at the end is emitted as the final item
		{CH_DOT, 1'b1, 1'b1, 2'd1, {CH_DOT, 1'b1, 1'b0}, NO_ITEM},
		// escaped byte
		{CH_BSL, 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"a",    1'b1, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		// repeat count with both bounds empty
		{CH_DOT,    1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{CH_LBRACE, 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{CH_COMMA,  1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{CH_RBRACE, 1'b1, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		// pattern ends right on the opening brace
		{CH_DOT,    1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{CH_LBRACE, 1'b1, 1'b1, 2'd1, SYNTAX_ERR, NO_ITEM},
		// non-digit inside braces; the rest of the pattern is swallowed
		{CH_DOT,    1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{CH_LBRACE, 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"x",       1'b0, 1'b1, 2'd1, SYNTAX_ERR, NO_ITEM},
		{"z",       1'b1, 1'b1, 2'd0, NO_ITEM, NO_ITEM},
		// pattern ends inside braces
		{CH_DOT,    1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{CH_LBRACE, 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
		{"3",       1'b1, 1'b1, 2'd1, SYNTAX_ERR, NO_ITEM}
	};

	wildcard_to_regex_escaper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),    // [7:0] pattern_byte
		.s_axis_tlast  (s_axis_tlast),    // pattern_end
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),    // [7:0] regex_byte
		.m_axis_tlast  (m_axis_tlast),    // regex_end
		.m_axis_tuser  (m_axis_tuser)     // [0] syntax_error
	);

	always #5 clk = ~clk;

	function automatic item_t regex_item(input logic [7:0] b, input logic fin);
		item_t t;
		t.regex_byte   = b;
		t.regex_end    = fin;
		t.syntax_error = 1'b0;
		return t;
	endfunction

	function automatic bit is_meta(input logic [7:0] b);
		for (int k = 0; k < 12; k++)
			if (META_SET[8*k +: 8] == b)
				return 1'b1;
		return 1'b0;
	endfunction

	// Scanner predictor: advances pred_mode by one pattern byte and returns
	// the regex items (zero, one or two) that byte should produce.
	task automatic predict_regex(input logic [7:0] b, input logic fin, output int n,
			output item_t r0, output item_t r1);
		logic       low;
		logic [7:0] sep;
		n = 0;
		r0 = NO_ITEM;
		r1 = NO_ITEM;
		case (pred_mode)
			MODE_DROP: begin
				if (fin)
					pred_mode = MODE_NORMAL;
			end
			MODE_ESCAPE: begin
				n = 2;
				r0 = regex_item(CH_BSL, 1'b0);
				r1 = regex_item(b, fin);
				pred_mode = MODE_NORMAL;
			end
			MODE_DOT: begin
				if (b == CH_DOT) begin
					// one dot goes out, the new one stays pending unless the pattern ends
					n = 1;
					r0 = regex_item(CH_DOT, 1'b0);
					if (fin) begin
						n = 2;
						r1 = regex_item(CH_DOT, 1'b1);
						pred_mode = MODE_NORMAL;
					end
				end else if (b == CH_LBRACE) begin
					if (fin) begin
						n = 1;
						r0 = SYNTAX_ERR;
						pred_mode = MODE_NORMAL;
					end else begin
						n = 2;
						r0 = regex_item(CH_DOT, 1'b0);
						r1 = regex_item(CH_LBRACE, 1'b0);
						pred_mode = MODE_COUNT_LOW;
					end
				end else begin
					n = 2;
					r0 = regex_item(CH_DOT, 1'b0);
					r1 = regex_item(b, fin);
					pred_mode = MODE_NORMAL;
				end
			end
			MODE_COUNT_LOW, MODE_COUNT_HIGH: begin
				low = (pred_mode == MODE_COUNT_LOW);
				sep = low ? CH_COMMA : CH_RBRACE;
				n = 1;
				if ((b != sep && (b < CH_ZERO || b > CH_NINE)) ||
						(fin && !(b == sep && !low))) begin
					r0 = SYNTAX_ERR;
					pred_mode = fin ? MODE_NORMAL : MODE_DROP;
				end else begin
					r0 = regex_item(b, fin);
					if (b == sep)
						pred_mode = low ? MODE_COUNT_HIGH : MODE_NORMAL;
				end
			end
			default: begin
				// normal mode; unused encodings behave the same
				pred_mode = MODE_NORMAL;
				if (b == CH_DOT) begin
					if (fin) begin
						n = 1;
						r0 = regex_item(CH_DOT, 1'b1);
					end else
						pred_mode = MODE_DOT;
				end else if (b == CH_BSL) begin
					if (fin) begin
						n = 1;
						r0 = SYNTAX_ERR;
					end else
						pred_mode = MODE_ESCAPE;
				end else if (is_meta(b)) begin
					n = 2;
					r0 = regex_item(CH_BSL, 1'b0);
					r1 = regex_item(b, fin);
				end else begin
					n = 1;
					r0 = regex_item(b, fin);
				end
			end
		endcase
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Offer one pattern byte, wait for the handshake, then queue what it should
	// produce. A typed row overrides the predictor's items; the predictor still
	// runs so that its mode follows the block.
	task automatic feed(input logic [7:0] b, input logic fin, input bit steady,
			input bit typed, input int tn, input item_t t0, input item_t t1);
		int    gap;
		int    n;
		bit    live;
		item_t r0;
		item_t r1;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		live = (pred_mode != MODE_DROP);
		predict_regex(b, fin, n, r0, r1);
		if (typed) begin
			n = tn;
			r0 = t0;
			r1 = t1;
		end
		if (n > 0)
			regex_due.push_back(r0);
		if (n > 1)
			regex_due.push_back(r1);
		if (live)
			items_fed++;
	endtask

	// Bytes that stress the count and escape logic.
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 6))
			0: return CH_DOT;
			1: return CH_LBRACE;
			2: return CH_RBRACE;
			3: return CH_COMMA;
			4: return CH_BSL;
			5: return CH_ZERO + 8'($urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Random pattern: mostly well-formed token runs, some broken ones
	// (truncated, one byte overwritten, trailing backslash), some pure noise.
	task automatic build_pattern();
		int style;
		int cut;
		int m;
		pattern_q.delete();
		style = $urandom_range(0, 99);
		if (style < 85) begin
			repeat ($urandom_range(1, 5)) begin
				case ($urandom_range(0, 6))
					0, 1: pattern_q.push_back(8'($urandom_range(0, 255)));
					2: begin
						m = $urandom_range(0, 11);
						pattern_q.push_back(META_SET[8*m +: 8]);
					end
					3: begin
						pattern_q.push_back(CH_BSL);
						pattern_q.push_back(8'($urandom_range(0, 255)));
					end
					4: begin
						pattern_q.push_back(CH_DOT);
						pattern_q.push_back(8'($urandom_range(0, 255)));
					end
					5: begin
						// .{low,high} repeat count, each bound 0..3 digits
						pattern_q.push_back(CH_DOT);
						pattern_q.push_back(CH_LBRACE);
						repeat ($urandom_range(0, 3))
							pattern_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
						pattern_q.push_back(CH_COMMA);
						repeat ($urandom_range(0, 3))
							pattern_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
						pattern_q.push_back(CH_RBRACE);
					end
					default: begin
						repeat ($urandom_range(1, 3))
							pattern_q.push_back(CH_DOT);
					end
				endcase
			end
			if (style >= 70) begin
				case ($urandom_range(0, 2))
					0: begin
						cut = $urandom_range(1, pattern_q.size());
						while (pattern_q.size() > cut)
							void'(pattern_q.pop_back());
					end
					1: pattern_q[$urandom_range(0, pattern_q.size() - 1)] = noise_byte();
					default: pattern_q.push_back(CH_BSL);
				endcase
			end
		end else begin
			repeat ($urandom_range(1, 6))
				pattern_q.push_back(noise_byte());
		end
	endtask

	// Sender: reset, directed table, random patterns, drain, verdict.
	initial begin
		bit steady;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		steady = 1'b0;
		foreach (dir_rows[k]) begin
			feed(dir_rows[k].pat, dir_rows[k].fin, steady, dir_rows[k].typed,
				dir_rows[k].n, dir_rows[k].r0, dir_rows[k].r1);
			if (dir_rows[k].fin)
				steady = ($urandom_range(0, 3) == 0);
		end

		while (items_fed < RANDOM_ITEMS) begin
			build_pattern();
			// now and then a whole pattern goes in back to back
			steady = ($urandom_range(0, 4) == 0);
			foreach (pattern_q[k])
				feed(pattern_q[k], k == pattern_q.size() - 1, steady, 1'b0, 0,
					NO_ITEM, NO_ITEM);
		end
		s_axis_tvalid <= 1'b0;

		while (regex_due.size() != 0)
			@(posedge clk);
		// allow the pipeline to show any stray item
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("wildcard_to_regex_escaper_test: done, clean");
		else
			$display("wildcard_to_regex_escaper_test: done, errors");
		$finish;
	end

	// Receiver: random stall per item, runs of no stall, and the long hold-off.
	initial begin
		int    stall;
		int    steady_left;
		item_t want;
		steady_left = 0;
		forever begin
			while (hold_off) begin
				m_axis_tready <= 1'b0;
				@(posedge clk);
			end
			if (steady_left > 0)
				steady_left--;
			else if ($urandom_range(0, 15) == 0)
				steady_left = 20;
			stall = (steady_left > 0) ? 0 : $urandom_range(0, 3);
			repeat (stall) begin
				m_axis_tready <= 1'b0;
				@(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			if (regex_due.size() == 0) begin
				note_mismatch($sformatf("unexpected item byte %h end %b err %b",
					m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
			end else begin
				want = regex_due.pop_front();
				if (m_axis_tdata !== want.regex_byte)
					note_mismatch($sformatf("regex_byte %h, want %h",
						m_axis_tdata, want.regex_byte));
				if (m_axis_tlast !== want.regex_end)
					note_mismatch($sformatf("regex_end %b, want %b",
						m_axis_tlast, want.regex_end));
				if (m_axis_tuser[0] !== want.syntax_error)
					note_mismatch($sformatf("syntax_error %b, want %b",
						m_axis_tuser[0], want.syntax_error));
			end
		end
	end

	// Back-pressure: twice the receiver holds off long enough for the output
	// queue to fill and s_axis_tready to drop while the sender keeps offering.
	initial begin
		wait (items_fed >= 50);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (120) @(posedge clk);
		hold_off <= 1'b0;
		wait (items_fed >= 1000);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (120) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog, several times the slowest clean run.
	initial begin
		#2_000_000;
		$display("wildcard_to_regex_escaper_test: done, errors");
		$finish;
	end

endmodule
